/* rtl/core/dis_pkg.sv */
// Shared types and constants for the disjoint interval set.
`default_nettype none
package dis_pkg;

    localparam int DATA_W = 16;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_DUMP = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] interval_start;
        logic [DATA_W-1:0] interval_end;
        logic              last;
        logic              empty_res;
        logic              overflow;
    } t_res;

    // flags from the shared compare unit, a against b
    typedef struct packed {
        logic ge;   // a >= b
        logic eq;   // a == b
        logic adj;  // a + 1 == b, no wrap
    } t_cmp;

endpackage
`default_nettype wire

/* rtl/core/dis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/dis_cmp.sv */
// Shared compare unit: ordering, equality and adjacency of two bounds.
`default_nettype none
module dis_cmp
    import dis_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  wire logic [VALUE_BITS-1:0] i_a,
    input  wire logic [VALUE_BITS-1:0] i_b,
    output t_cmp                       o_cmp
);

    logic [VALUE_BITS:0] w_a_inc;

    // one extra bit so the top value never looks adjacent to zero
    assign w_a_inc     = {1'b0, i_a} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign o_cmp.ge    = (i_a >= i_b);
    assign o_cmp.eq    = (i_a == i_b);
    assign o_cmp.adj   = (w_a_inc == {1'b0, i_b});

endmodule
`default_nettype wire

/* rtl/core/disjoint_interval_set.sv */
// Top level: sorted interval table with add and dump requests.
//
// Keeps up to MAX_INTERVALS disjoint closed intervals in one table RAM
// (start and end per row), empty after reset. A request is taken when
// i_start is high and o_busy is low. An add reads and compares each row
// from the bottom in the shared compare unit, checks the previous and
// next rows and decides; a covered value changes nothing, a patch is one
// write, an insert shifts later rows up (check, read, write), closes with
// a check and writes the new row, a merge writes the joined row and shifts
// later rows down; it never produces a result. A dump returns each
// interval on o_res with a one-cycle o_res_valid strobe, the last one
// flagged; an empty table returns a single result with empty_res set in
// the cycle after the request. Results cannot be held off. An insert into
// a full table is dropped and sets the sticky overflow flag carried on
// every result. The table needs no clearing after reset.
`default_nettype none
module disjoint_interval_set
    import dis_pkg::*;
#(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_res_valid,
    output t_res      o_res
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int IW = $clog2(MAX_INTERVALS + 1);
    localparam int VB = VALUE_BITS;
    localparam int RW = 2 * VB;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SCAN_RD  = 11'b000_0000_0010,
        S_SCAN_CHK = 11'b000_0000_0100,
        S_CHK_PREV = 11'b000_0000_1000,
        S_CHK_NEXT = 11'b000_0001_0000,
        S_DECIDE   = 11'b000_0010_0000,
        S_WRITE    = 11'b000_0100_0000,
        S_MOVE_CHK = 11'b000_1000_0000,
        S_MOVE_RD  = 11'b001_0000_0000,
        S_MOVE_WR  = 11'b010_0000_0000,
        S_DUMP_RD  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_PATCH  = 2'd0,
        OP_MERGE  = 2'd1,
        OP_INSERT = 2'd2
    } t_op;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic            r_dump_out, n_dump_out;
    logic [IW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_pos, n_pos;
    logic            r_lost, n_lost;
    logic [VB-1:0]   r_val, n_val;
    logic [VB-1:0]   r_prev_start, n_prev_start;
    logic [VB-1:0]   r_prev_end, n_prev_end;
    logic [VB-1:0]   r_next_start, n_next_start;
    logic [VB-1:0]   r_next_end, n_next_end;
    logic            r_has_next, n_has_next;
    logic            r_cov, n_cov;
    logic            r_tp, n_tp;
    logic            r_tn, n_tn;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic [RW-1:0]   r_wr_data, n_wr_data;
    logic            r_out_vld, n_out_vld;
    t_res            r_out, n_out;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [RW-1:0]   w_wdata;
    logic [IW-1:0]   w_raddr;
    logic [RW-1:0]   w_rdata;
    logic [VB-1:0]   w_rd_start;
    logic [VB-1:0]   w_rd_end;
    logic [VB-1:0]   w_cmp_a;
    logic [VB-1:0]   w_cmp_b;
    t_cmp            w_cmp;
    logic            w_accept;
    logic            w_has_prev;
    logic [IW-1:0]   w_idx_inc;
    logic [IW-1:0]   w_idx_dec;
    logic [IW-1:0]   w_pos_dec;
    logic [VB+DATA_W-1:0] w_val_wide;
    logic [VB+DATA_W-1:0] w_start_wide;
    logic [VB+DATA_W-1:0] w_end_wide;

    dis_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    dis_cmp #(
        .VALUE_BITS (VB)
    ) u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_cmp (w_cmp)
    );

    assign w_rd_start   = w_rdata[RW-1:VB];
    assign w_rd_end     = w_rdata[VB-1:0];
    assign w_accept     = i_start && !o_busy;
    assign w_has_prev   = (r_pos != '0);
    assign w_idx_inc    = r_idx + IW'(1);
    assign w_idx_dec    = r_idx - IW'(1);
    assign w_pos_dec    = r_pos - IW'(1);
    assign w_val_wide   = {{VB{1'b0}}, i_req.value};
    assign w_start_wide = {{DATA_W{1'b0}}, w_rd_start};
    assign w_end_wide   = {{DATA_W{1'b0}}, w_rd_end};

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    always_comb begin
        unique case (r_state)
            S_SCAN_CHK: begin
                w_cmp_a = w_rd_start;
                w_cmp_b = r_val;
            end
            S_CHK_PREV: begin
                w_cmp_a = r_prev_end;
                w_cmp_b = r_val;
            end
            default: begin
                w_cmp_a = r_val;
                w_cmp_b = r_next_start;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_dump_out   = 1'b0;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_lost       = r_lost;
        n_val        = r_val;
        n_prev_start = r_prev_start;
        n_prev_end   = r_prev_end;
        n_next_start = r_next_start;
        n_next_end   = r_next_end;
        n_has_next   = r_has_next;
        n_cov        = r_cov;
        n_tp         = r_tp;
        n_tn         = r_tn;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_out_vld    = 1'b0;
        n_out        = r_out;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = r_wr_data;
        w_raddr      = r_idx;

        // dump row read last cycle is on the RAM output now
        if (r_dump_out) begin
            n_out_vld          = 1'b1;
            n_out.interval_start = w_start_wide[DATA_W-1:0];
            n_out.interval_end = w_end_wide[DATA_W-1:0];
            n_out.last         = (w_idx_inc == r_count);
            n_out.empty_res    = 1'b0;
            n_out.overflow     = r_lost;
            n_idx              = w_idx_inc;
            n_state            = (w_idx_inc == r_count) ? S_IDLE : S_DUMP_RD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    if (i_req.action == ACT_DUMP) begin
                        if (r_count == '0) begin
                            n_out_vld            = 1'b1;
                            n_out.interval_start = '0;
                            n_out.interval_end   = '0;
                            n_out.last           = 1'b1;
                            n_out.empty_res      = 1'b1;
                            n_out.overflow       = r_lost;
                        end else begin
                            n_state = S_DUMP_RD;
                        end
                    end else begin
                        n_val = w_val_wide[VB-1:0];
                        if (r_count == '0) begin
                            n_pos      = '0;
                            n_has_next = 1'b0;
                            n_state    = S_CHK_PREV;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                w_raddr = r_idx;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (w_cmp.ge) begin
                    n_pos        = r_idx;
                    n_has_next   = 1'b1;
                    n_next_start = w_rd_start;
                    n_next_end   = w_rd_end;
                    n_state      = S_CHK_PREV;
                end else begin
                    n_prev_start = w_rd_start;
                    n_prev_end   = w_rd_end;
                    n_idx        = w_idx_inc;
                    if (w_idx_inc == r_count) begin
                        n_pos      = r_count;
                        n_has_next = 1'b0;
                        n_state    = S_CHK_PREV;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_CHK_PREV: begin
                n_cov   = w_has_prev && w_cmp.ge;
                n_tp    = w_has_prev && w_cmp.adj;
                n_state = S_CHK_NEXT;
            end
            S_CHK_NEXT: begin
                n_cov   = r_cov || (r_has_next && w_cmp.eq);
                n_tn    = r_has_next && w_cmp.adj;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (r_cov) begin
                    n_state = S_IDLE;
                end else if (r_tp && r_tn) begin
                    n_wr_addr = w_pos_dec[AW-1:0];
                    n_wr_data = {r_prev_start, r_next_end};
                    n_op      = OP_MERGE;
                    n_idx     = r_pos;
                    n_state   = S_WRITE;
                end else if (r_tp) begin
                    n_wr_addr = w_pos_dec[AW-1:0];
                    n_wr_data = {r_prev_start, r_val};
                    n_op      = OP_PATCH;
                    n_state   = S_WRITE;
                end else if (r_tn) begin
                    n_wr_addr = r_pos[AW-1:0];
                    n_wr_data = {r_val, r_next_end};
                    n_op      = OP_PATCH;
                    n_state   = S_WRITE;
                end else if (r_count == IW'(MAX_INTERVALS)) begin
                    n_lost  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_wr_addr = r_pos[AW-1:0];
                    n_wr_data = {r_val, r_val};
                    n_op      = OP_INSERT;
                    n_idx     = r_count;
                    n_state   = S_MOVE_CHK;
                end
            end
            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = IW'(r_wr_addr);
                w_wdata = r_wr_data;
                unique case (r_op)
                    OP_MERGE:  n_state = S_MOVE_CHK;
                    OP_INSERT: begin
                        n_count = r_count + IW'(1);
                        n_state = S_IDLE;
                    end
                    default:   n_state = S_IDLE;
                endcase
            end
            S_MOVE_CHK: begin
                if (r_op == OP_MERGE) begin
                    if (w_idx_inc < r_count) begin
                        n_state = S_MOVE_RD;
                    end else begin
                        n_count = r_count - IW'(1);
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = (r_idx > r_pos) ? S_MOVE_RD : S_WRITE;
                end
            end
            S_MOVE_RD: begin
                w_raddr = (r_op == OP_MERGE) ? w_idx_inc : w_idx_dec;
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = (r_op == OP_MERGE) ? w_idx_inc : w_idx_dec;
                n_state = S_MOVE_CHK;
            end
            S_DUMP_RD: begin
                // issue a row read only when no row is on its way out
                if (!r_dump_out) begin
                    w_raddr    = r_idx;
                    n_dump_out = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // while a dump row is on its way out, hold off the next read
        if (r_state == S_DUMP_RD && r_dump_out) begin
            n_dump_out = 1'b0;
            w_raddr    = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_PATCH;
            r_dump_out <= 1'b0;
            r_count    <= '0;
            r_lost     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_dump_out <= n_dump_out;
            r_count    <= n_count;
            r_lost     <= n_lost;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_prev_start <= n_prev_start;
        r_prev_end   <= n_prev_end;
        r_next_start <= n_next_start;
        r_next_end   <= n_next_end;
        r_has_next   <= n_has_next;
        r_cov        <= n_cov;
        r_tp         <= n_tp;
        r_tn         <= n_tn;
        r_wr_addr    <= n_wr_addr;
        r_wr_data    <= n_wr_data;
        r_out        <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(MAX_INTERVALS))
        else $error("interval count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + IW'(1)) || (r_count + IW'(1) == $past(r_count)))
        else $error("interval count moved by more than one");

    a_lost_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lost |=> r_lost)
        else $error("overflow flag cleared without reset");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_vld |-> (r_dump_out || (w_accept && i_req.action == ACT_DUMP)))
        else $error("result strobe without a dump in progress");

    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req.action == ACT_ADD) |=> o_busy && !o_res_valid)
        else $error("add request did not occupy the block");

endmodule
`default_nettype wire
